// ===== rtl/ccit_pkg.sv =====
package ccit_pkg;

    // Operation codes carried in the mode field of an item.
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_COUNT = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Field widths fixed by the item format.
    localparam int unsigned COORD_W = 8;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned XING_W  = 16;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned Z_W     = 11;

    // Crossing value of -1.0 in Q12.4 marks a column as empty.
    localparam logic signed [XING_W-1:0] EMPTY_MARK = -16'sd16;

endpackage

// ===== rtl/column_crossing_inside_test_top.sv =====
// Point-in-solid test by scanline parity over a GRID_X by GRID_Y grid of columns. Each column
// keeps up to MAX_CROSSINGS ascending boundary heights (Q12.4) in a crossing memory and a
// crossing count in a count memory. Mode 0 writes one crossing, mode 1 sets a column count
// (saturated at MAX_CROSSINGS), mode 2 queries a point and returns one inside_res item;
// negative or out-of-grid columns are ignored for writes and answer outside for queries.
// After reset the count memory is cleared in one pass over all GRID_X*GRID_Y columns, during
// which no item is accepted. The block handles one item at a time: a write or count item is
// taken in idle and done in exec. A query reads the column count and first crossing in exec,
// examines the stored crossings in order in scan, at least one and at most the column count
// (one for an empty column); a query on a negative or out-of-grid column skips the scan. The
// pace is set by the one-read-per-cycle port of the crossing memory. A finished result waits in
// the output register while the next item is already accepted; if that register still holds an
// earlier result that has not been taken, the query waits in its result state until it is.
module column_crossing_inside_test_top #(
    parameter int unsigned GRID_X        = 64,
    parameter int unsigned GRID_Y        = 64,
    parameter int unsigned MAX_CROSSINGS = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [1:0]                               mode,
    input  logic signed [ccit_pkg::COORD_W-1:0]      col_x,
    input  logic signed [ccit_pkg::COORD_W-1:0]      col_y,
    input  logic [ccit_pkg::SLOT_W-1:0]              slot,
    input  logic signed [ccit_pkg::XING_W-1:0]       crossing,
    input  logic [ccit_pkg::COUNT_W-1:0]             count,
    input  logic [ccit_pkg::Z_W-1:0]                 point_z,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     inside_res
);

    localparam int unsigned NCOL       = GRID_X * GRID_Y;
    localparam int unsigned COL_W      = (NCOL > 1) ? $clog2(NCOL) : 1;
    localparam int unsigned XING_DEPTH = NCOL * MAX_CROSSINGS;
    localparam int unsigned XA_W       = (XING_DEPTH > 1) ? $clog2(XING_DEPTH) : 1;
    localparam int unsigned IDX_W      = $clog2(MAX_CROSSINGS);
    localparam int unsigned POS_W      = (IDX_W + 1 > ccit_pkg::COUNT_W) ?
                                         IDX_W + 1 : ccit_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t                             state_reg;
    logic [COL_W-1:0]                   clr_cnt_reg;
    logic [IDX_W-1:0]                   idx_reg;
    logic                               res_reg;
    logic                               out_valid_reg;
    logic                               inside_res_reg;

    logic [1:0]                         mode_reg;
    logic signed [ccit_pkg::COORD_W-1:0] col_x_reg;
    logic signed [ccit_pkg::COORD_W-1:0] col_y_reg;
    logic [ccit_pkg::SLOT_W-1:0]        slot_reg;
    logic signed [ccit_pkg::XING_W-1:0] crossing_reg;
    logic [ccit_pkg::COUNT_W-1:0]       count_reg;
    logic [ccit_pkg::Z_W-1:0]           point_z_reg;

    logic                               col_ok;
    logic                               slot_ok;
    logic [COL_W-1:0]                   col_idx;
    logic [XA_W-1:0]                    col_base;
    logic [ccit_pkg::COUNT_W-1:0]       cnt_sat;

    logic                               cnt_we;
    logic [COL_W-1:0]                   cnt_wa;
    logic [ccit_pkg::COUNT_W-1:0]       cnt_wd;
    logic                               cnt_re;
    logic [ccit_pkg::COUNT_W-1:0]       cnt_rd;

    logic                               x_we;
    logic [XA_W-1:0]                    x_wa;
    logic                               x_re;
    logic [XA_W-1:0]                    x_ra;
    logic [ccit_pkg::XING_W-1:0]        x_rd;

    logic signed [ccit_pkg::XING_W-1:0] cur_xing;
    logic signed [ccit_pkg::XING_W-1:0] zq;
    logic [POS_W-1:0]                   pos_cur;
    logic [POS_W-1:0]                   pos_inc;
    logic [POS_W-1:0]                   len_ext;
    logic [IDX_W-1:0]                   idx_rd;
    logic                               scan_done;
    logic                               scan_res;

    // Column address and range checks on the held item.
    always_comb
    begin
        col_ok  = !col_x_reg[ccit_pkg::COORD_W-1] && !col_y_reg[ccit_pkg::COORD_W-1] &&
                  (int'(col_x_reg[ccit_pkg::COORD_W-2:0]) < GRID_X) &&
                  (int'(col_y_reg[ccit_pkg::COORD_W-2:0]) < GRID_Y);
        slot_ok = int'(slot_reg) < MAX_CROSSINGS;
        col_idx = COL_W'(int'(col_x_reg[ccit_pkg::COORD_W-2:0]) * GRID_Y +
                         int'(col_y_reg[ccit_pkg::COORD_W-2:0]));
        col_base = XA_W'(int'(col_idx) * MAX_CROSSINGS);
        cnt_sat = (int'(count_reg) > MAX_CROSSINGS) ?
                  ccit_pkg::COUNT_W'(MAX_CROSSINGS) : count_reg;
    end

    // Scan step: judge the crossing read for the current slot.
    always_comb
    begin
        cur_xing  = ccit_pkg::XING_W'(x_rd);
        zq        = signed'({1'b0, point_z_reg, 4'b0000});
        pos_cur   = POS_W'(idx_reg);
        pos_inc   = pos_cur + POS_W'(1);
        len_ext   = POS_W'(cnt_rd);
        idx_rd    = (int'(pos_inc) < MAX_CROSSINGS) ? IDX_W'(pos_inc) : idx_reg;
        scan_done = 1'b1;
        scan_res  = 1'b0;
        priority if ((idx_reg == '0) &&
                     ((cnt_rd == '0) || (cur_xing == ccit_pkg::EMPTY_MARK)))
        begin
            scan_res = 1'b0;
        end
        else if (cur_xing == zq)
        begin
            scan_res = 1'b1;
        end
        else if (cur_xing > zq)
        begin
            // Outside at position zero, or when both sides hold an even number.
            scan_res = (pos_cur != '0) && !(!pos_cur[0] && cnt_rd[0]);
        end
        else if (pos_inc == len_ext)
        begin
            scan_res = 1'b0;
        end
        else
        begin
            scan_done = 1'b0;
        end
    end

    // Memory port controls.
    always_comb
    begin
        cnt_we = (state_reg == ST_CLEAR) ||
                 ((state_reg == ST_EXEC) && (mode_reg == ccit_pkg::MODE_COUNT) && col_ok);
        cnt_wa = (state_reg == ST_CLEAR) ? clr_cnt_reg : col_idx;
        cnt_wd = (state_reg == ST_CLEAR) ? '0 : cnt_sat;
        cnt_re = (state_reg == ST_EXEC) && (mode_reg == ccit_pkg::MODE_QUERY);
        x_we   = (state_reg == ST_EXEC) && (mode_reg == ccit_pkg::MODE_WRITE) &&
                 col_ok && slot_ok;
        x_wa   = col_base + XA_W'(slot_reg);
        x_re   = cnt_re || (state_reg == ST_SCAN);
        x_ra   = (state_reg == ST_EXEC) ? col_base : col_base + XA_W'(idx_rd);
    end

    ccit_ram #(
        .WIDTH (ccit_pkg::COUNT_W),
        .DEPTH (NCOL)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_wa),
        .wr_data (cnt_wd),
        .rd_en   (cnt_re),
        .rd_addr (col_idx),
        .rd_data (cnt_rd)
    );

    ccit_ram #(
        .WIDTH (ccit_pkg::XING_W),
        .DEPTH (XING_DEPTH)
    ) u_xing_ram (
        .clk     (clk),
        .wr_en   (x_we),
        .wr_addr (x_wa),
        .wr_data (crossing_reg),
        .rd_en   (x_re),
        .rd_addr (x_ra),
        .rd_data (x_rd)
    );

    // Sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The result state loads the output register itself.
            if (out_valid_reg && !out_stall && (state_reg != ST_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + COL_W'(1);
                    if (clr_cnt_reg == COL_W'(NCOL - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg     <= mode;
                        col_x_reg    <= col_x;
                        col_y_reg    <= col_y;
                        slot_reg     <= slot;
                        crossing_reg <= crossing;
                        count_reg    <= count;
                        point_z_reg  <= point_z;
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    idx_reg <= '0;
                    unique case (mode_reg)
                        ccit_pkg::MODE_QUERY:
                        begin
                            if (col_ok)
                            begin
                                state_reg <= ST_SCAN;
                            end
                            else
                            begin
                                res_reg   <= 1'b0;
                                state_reg <= ST_RESULT;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_SCAN:
                begin
                    if (scan_done)
                    begin
                        res_reg   <= scan_res;
                        state_reg <= ST_RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_RESULT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        inside_res_reg <= res_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;

endmodule

// ===== rtl/ccit_ram.sv =====
module ccit_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int GRID      = 64;
    localparam int DEPTH     = 8;
    localparam int NCOLS     = GRID * GRID;
    localparam int HOT_COLS  = 8;
    localparam int CYCLE_CAP = 400000;

    // How an item's result is checked: by the predictor, or against a fixed value.
    typedef enum logic [1:0] {WANT_PREDICT, WANT_OUTSIDE, WANT_INSIDE} want_t;

    typedef struct {
        logic [1:0]                          mode;
        logic signed [ccit_pkg::COORD_W-1:0] x;
        logic signed [ccit_pkg::COORD_W-1:0] y;
        logic [ccit_pkg::SLOT_W-1:0]         slot;
        logic signed [ccit_pkg::XING_W-1:0]  xing;
        logic [ccit_pkg::COUNT_W-1:0]        cnt;
        logic [ccit_pkg::Z_W-1:0]            z;
        want_t                               want;
    } column_op_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [1:0]                          mode;
    logic signed [ccit_pkg::COORD_W-1:0] col_x;
    logic signed [ccit_pkg::COORD_W-1:0] col_y;
    logic [ccit_pkg::SLOT_W-1:0]         slot;
    logic signed [ccit_pkg::XING_W-1:0]  crossing;
    logic [ccit_pkg::COUNT_W-1:0]        count;
    logic [ccit_pkg::Z_W-1:0]            point_z;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic                                inside_res;

    // Predictor state: crossing heights, which slots hold a value, and column counts.
    logic signed [ccit_pkg::XING_W-1:0]  xing_mem [0:NCOLS*DEPTH-1];
    bit                                  slot_written [0:NCOLS*DEPTH-1];
    logic [ccit_pkg::COUNT_W-1:0]        col_len [0:NCOLS-1];

    bit                                  inside_due [$];
    column_op_t                          directed_ops [$];
    int                                  hot_x [HOT_COLS];
    int                                  hot_y [HOT_COLS];

    int                                  idle_pct;
    int                                  stall_pct;
    int                                  mismatches = 0;
    int                                  results_checked = 0;
    int                                  cycle_count = 0;
    int                                  n_writes;
    int                                  n_counts;
    int                                  n_queries;
    int                                  n_unused;

    column_crossing_inside_test_top #(
        .GRID_X        (GRID),
        .GRID_Y        (GRID),
        .MAX_CROSSINGS (DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .col_x      (col_x),
        .col_y      (col_y),
        .slot       (slot),
        .crossing   (crossing),
        .count      (count),
        .point_z    (point_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res)
    );

    always #5 clk = ~clk;

    // Column index in the grid, or -1 for a negative or out-of-grid column.
    function automatic int col_index(input logic signed [ccit_pkg::COORD_W-1:0] x,
                                     input logic signed [ccit_pkg::COORD_W-1:0] y);
        int xi;
        int yi;
        xi = int'(x);
        yi = int'(y);
        if (xi < 0 || yi < 0 || xi >= GRID || yi >= GRID)
            return -1;
        return xi * GRID + yi;
    endfunction

    // Parity scan of one column for the point at integer height z.
    function automatic bit predict_inside(input int idx, input logic [ccit_pkg::Z_W-1:0] z);
        int n;
        int zq;
        int below;
        int c;
        int i;
        bit hit;
        bit stop;
        n = int'(col_len[idx]);
        zq = int'(z) * 16;
        below = 0;
        hit = 1'b0;
        stop = 1'b0;
        if (n == 0 || xing_mem[idx * DEPTH] == ccit_pkg::EMPTY_MARK)
            return 1'b0;
        for (i = 0; i < n && !stop && !hit; i++)
        begin
            c = int'(xing_mem[idx * DEPTH + i]);
            if (c == zq)
                hit = 1'b1;
            else if (c > zq)
                stop = 1'b1;
            else
                below++;
        end
        if (hit)
            return 1'b1;
        if (below == 0 || below == n)
            return 1'b0;
        if (below % 2 == 0 && (n - below - 1) % 2 == 0)
            return 1'b0;
        return 1'b1;
    endfunction

    // Updates the predicted state for one accepted item and gives its result, if any.
    function automatic void apply_column_op(input column_op_t op, output bit has_res,
                                            output bit res);
        int idx;
        idx = col_index(op.x, op.y);
        has_res = 1'b0;
        res = 1'b0;
        case (op.mode)
            ccit_pkg::MODE_WRITE:
            begin
                if (idx >= 0 && op.slot < DEPTH)
                begin
                    xing_mem[idx * DEPTH + op.slot] = op.xing;
                    slot_written[idx * DEPTH + op.slot] = 1'b1;
                end
            end
            ccit_pkg::MODE_COUNT:
            begin
                if (idx >= 0)
                    col_len[idx] = (op.cnt > DEPTH) ? ccit_pkg::COUNT_W'(DEPTH) : op.cnt;
            end
            ccit_pkg::MODE_QUERY:
            begin
                has_res = 1'b1;
                res = (idx >= 0) ? predict_inside(idx, op.z) : 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // A query may only scan slots that have been written since reset.
    function automatic bit query_is_safe(input column_op_t op);
        int idx;
        int i;
        idx = col_index(op.x, op.y);
        if (idx < 0)
            return 1'b1;
        for (i = 0; i < col_len[idx]; i++)
            if (!slot_written[idx * DEPTH + i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic column_op_t mk_op(input logic [1:0] m, input int x, input int y,
                                         input int s, input int xing, input int cnt,
                                         input int z, input want_t w);
        column_op_t op;
        op.mode = m;
        op.x = ccit_pkg::COORD_W'(x);
        op.y = ccit_pkg::COORD_W'(y);
        op.slot = ccit_pkg::SLOT_W'(s);
        op.xing = ccit_pkg::XING_W'(xing);
        op.cnt = ccit_pkg::COUNT_W'(cnt);
        op.z = ccit_pkg::Z_W'(z);
        op.want = w;
        return op;
    endfunction

    // Appends one row to the directed table.
    function automatic void queue_op(input column_op_t op);
        directed_ops = {directed_ops, op};
    endfunction

    // Fully random item; every field carries random bits even where unused.
    function automatic column_op_t random_op();
        column_op_t op;
        op.mode = 2'($urandom_range(0, 3));
        op.x = ccit_pkg::COORD_W'(($urandom_range(0, 1) == 0) ?
                                  $urandom() : $urandom_range(0, GRID - 1));
        op.y = ccit_pkg::COORD_W'(($urandom_range(0, 1) == 0) ?
                                  $urandom() : $urandom_range(0, GRID - 1));
        op.slot = ccit_pkg::SLOT_W'($urandom());
        op.xing = ccit_pkg::XING_W'($urandom());
        op.cnt = ccit_pkg::COUNT_W'($urandom());
        op.z = ccit_pkg::Z_W'($urandom());
        op.want = WANT_PREDICT;
        return op;
    endfunction

    // Presents one item, with random idle cycles first, and waits for it to be taken.
    task automatic send_op(input column_op_t op);
        bit has_res;
        bit res;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op.mode;
        col_x    <= op.x;
        col_y    <= op.y;
        slot     <= op.slot;
        crossing <= op.xing;
        count    <= op.cnt;
        point_z  <= op.z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_column_op(op, has_res, res);
        case (op.mode)
            ccit_pkg::MODE_WRITE: n_writes++;
            ccit_pkg::MODE_COUNT: n_counts++;
            ccit_pkg::MODE_QUERY: n_queries++;
            default:              n_unused++;
        endcase
        if (has_res)
        begin
            if (op.want == WANT_OUTSIDE)
                res = 1'b0;
            else if (op.want == WANT_INSIDE)
                res = 1'b1;
            inside_due = {inside_due, res};
        end
    endtask

    // Holds the sender back until every outstanding query has answered.
    task automatic drain_queries();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (inside_due.size() != 0);
    endtask

    // Writes an ascending crossing list into a hot column, sets its count and
    // probes heights around and on the crossings.
    task automatic profile_column(input int h);
        int val [DEPTH];
        int n;
        int base;
        int i;
        int k;
        int lo;
        int hi;
        column_op_t op;
        n = $urandom_range(1, DEPTH);
        base = int'($urandom_range(0, 2100)) - 40;
        val[0] = base * 16 + (($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 15)));
        for (i = 1; i < DEPTH; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                val[i] = val[i - 1] + 16 * int'($urandom_range(1, 4));
            else
                val[i] = val[i - 1] + int'($urandom_range(1, 80));
        end
        for (i = 0; i < DEPTH; i++)
            if (val[i] > 32767)
                val[i] = 32767;
        if ($urandom_range(0, 19) == 0)
            val[0] = int'(ccit_pkg::EMPTY_MARK);
        for (i = 0; i < n; i++)
        begin
            op = random_op();
            op.mode = ccit_pkg::MODE_WRITE;
            op.x = ccit_pkg::COORD_W'(hot_x[h]);
            op.y = ccit_pkg::COORD_W'(hot_y[h]);
            op.slot = ccit_pkg::SLOT_W'(i);
            op.xing = ccit_pkg::XING_W'(val[i]);
            send_op(op);
        end
        op = random_op();
        op.mode = ccit_pkg::MODE_COUNT;
        op.x = ccit_pkg::COORD_W'(hot_x[h]);
        op.y = ccit_pkg::COORD_W'(hot_y[h]);
        op.cnt = ccit_pkg::COUNT_W'(n);
        if (n == DEPTH && $urandom_range(0, 1) == 0)
            op.cnt = ccit_pkg::COUNT_W'($urandom_range(DEPTH + 1, 15));
        send_op(op);
        lo = (val[0] >>> 4) - 2;
        hi = (val[n - 1] >>> 4) + 2;
        if (lo < 0)
            lo = 0;
        if (hi > 2047)
            hi = 2047;
        if (lo > hi)
        begin
            lo = 0;
            hi = 3;
        end
        for (k = $urandom_range(2, 6); k > 0; k--)
        begin
            op = random_op();
            op.mode = ccit_pkg::MODE_QUERY;
            op.x = ccit_pkg::COORD_W'(hot_x[h]);
            op.y = ccit_pkg::COORD_W'(hot_y[h]);
            op.z = ccit_pkg::Z_W'($urandom_range(lo, hi));
            send_op(op);
        end
    endtask

    // Result checker; also draws the receiver's stall for the next cycle.
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (inside_due.size() == 0)
            begin
                $display("%0t: inside_res %0b arrived with no query outstanding",
                         $time, inside_res);
                mismatches++;
            end
            else
            begin
                want = inside_due.pop_front();
                results_checked++;
                if (inside_res !== want)
                begin
                    $display("%0t: inside_res mismatch, expected %0b, got %0b",
                             $time, want, inside_res);
                    mismatches++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, inside_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int i;
        int h;
        int ph;
        int start;
        column_op_t op;

        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = ccit_pkg::MODE_NONE;
        col_x = '0;
        col_y = '0;
        slot = '0;
        crossing = '0;
        count = '0;
        point_z = '0;
        idle_pct = 0;
        stall_pct = 0;
        n_writes = 0;
        n_counts = 0;
        n_queries = 0;
        n_unused = 0;
        for (i = 0; i < NCOLS * DEPTH; i++)
        begin
            xing_mem[i] = '0;
            slot_written[i] = 1'b0;
        end
        for (i = 0; i < NCOLS; i++)
            col_len[i] = '0;

        // Directed corners: grid edges, parity outcomes, saturation, empty mark.
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    0,    0, 0,      0,  0,    0, WANT_OUTSIDE));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,   -1,    5, 0,      0,  0,    5, WANT_OUTSIDE));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,   64,    0, 0,      0,  0,    0, WANT_OUTSIDE));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    5, -128, 0,      0,  0,    1, WANT_OUTSIDE));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,  127,  127, 7,     -1, 15, 2047, WANT_OUTSIDE));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,    0,    0, 0,     16,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,    0,    0, 1,     80,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,    0,    0, 2,    160,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,    0,    0, 3,    320,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,   -1,   -1, 0, -32768,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_COUNT,    0,    0, 0,      0,  4,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    0,    0, 0,      0,  0,    0, WANT_OUTSIDE));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    0,    0, 0,      0,  0,    1, WANT_INSIDE));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    0,    0, 0,      0,  0,    3, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    0,    0, 0,      0,  0,    7, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    0,    0, 0,      0,  0, 2047, WANT_OUTSIDE));
        queue_op(mk_op(ccit_pkg::MODE_COUNT,    0,    0, 0,      0,  3,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    0,    0, 0,      0,  0,    7, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,    0,    0, 4,  32767,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,    0,    0, 5, -32768,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,    0,    0, 6,      0,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,    0,    0, 7,  32767,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_COUNT,    0,    0, 0,      0, 15,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    0,    0, 0,      0,  0, 2047, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_NONE,     0,    0, 7,     16, 15,    1, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_WRITE,    0,    0, 0,    -16,  0,    0, WANT_PREDICT));
        queue_op(mk_op(ccit_pkg::MODE_QUERY,    0,    0, 0,      0,  0,    5, WANT_OUTSIDE));

        // Single reset at the start; the block then clears its count memory.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
            send_op(directed_ops[i]);
        drain_queries();

        // Hot columns: the four grid corners and four random ones, fully written.
        hot_x[0] = 0;
        hot_y[0] = 0;
        hot_x[1] = 0;
        hot_y[1] = GRID - 1;
        hot_x[2] = GRID - 1;
        hot_y[2] = 0;
        hot_x[3] = GRID - 1;
        hot_y[3] = GRID - 1;
        for (h = 4; h < HOT_COLS; h++)
        begin
            hot_x[h] = $urandom_range(0, GRID - 1);
            hot_y[h] = $urandom_range(0, GRID - 1);
        end
        for (h = 0; h < HOT_COLS; h++)
            for (i = 0; i < DEPTH; i++)
            begin
                op = random_op();
                op.mode = ccit_pkg::MODE_WRITE;
                op.x = ccit_pkg::COORD_W'(hot_x[h]);
                op.y = ccit_pkg::COORD_W'(hot_y[h]);
                op.slot = ccit_pkg::SLOT_W'(i);
                send_op(op);
            end

        // Random phases, cycling through four idling patterns, each phase ending in a drain.
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            start = n_writes + n_counts + n_queries + n_unused;
            while (n_writes + n_counts + n_queries + n_unused - start < 85)
            begin
                if ($urandom_range(0, 9) < 7)
                    profile_column($urandom_range(0, HOT_COLS - 1));
                else
                begin
                    op = random_op();
                    if (op.mode == ccit_pkg::MODE_QUERY && !query_is_safe(op))
                    begin
                        h = $urandom_range(0, HOT_COLS - 1);
                        op.x = ccit_pkg::COORD_W'(hot_x[h]);
                        op.y = ccit_pkg::COORD_W'(hot_y[h]);
                    end
                    send_op(op);
                end
            end
            drain_queries();
        end

        // Allow for any stray result after the last expected one.
        idle_pct = 0;
        stall_pct = 0;
        repeat (30) @(posedge clk);

        $display("Checked %0d query results from %0d writes, %0d count settings,",
                 results_checked, n_writes, n_counts);
        $display("%0d queries and %0d unused-mode items over four idling patterns.",
                 n_queries, n_unused);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
